### sv/fwa_pkg.sv
// Shared types and constants for the bounded FIFO window average block.
package fwa_pkg;

	localparam int TAG_W    = 12;
	localparam int HEIGHT_W = 10;
	localparam int MEAN_W   = 10;
	localparam int HELD_W   = 3;
	localparam int ENTRY_W  = TAG_W + HEIGHT_W;
	localparam int STEP_W   = $clog2(MEAN_W);

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	typedef struct packed {
		logic                mode;
		logic [TAG_W-1:0]    entry_tag;
		logic [HEIGHT_W-1:0] entry_height;
	} fwa_cmd_t;

	typedef struct packed {
		logic                kind;
		logic [MEAN_W-1:0]   mean_height;
		logic [TAG_W-1:0]    removed_tag;
		logic                empty_error;
		logic [HELD_W-1:0]   held_count;
	} fwa_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_FINISH
	} fwa_state_t;

endpackage

### sv/fwa_stream_if.sv
// Valid/ready stream channel carrying one payload item per handshake.
interface fwa_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### sv/bounded_fifo_window_average_top.sv
// Bounded FIFO window average: ring buffer in a synchronous RAM, running sum, serial mean divider.
// An accepted command passes through ST_EXEC (queue update), then for an insert the ST_DIV steps of the
// restoring divider, which retires one mean bit per cycle, then ST_FINISH, which loads the output register.
// A new command is taken only in ST_IDLE, so the block finishes one item before it takes the next.
// A finished result waits in the output register while the next item is taken.
// Reset (arst_n low) empties the queue and clears the sum; the entry RAM is not cleared.
module bounded_fifo_window_average_top #(
	parameter int CAPACITY = 5
) (
	input logic clk,
	input logic arst_n,
	fwa_stream_if.sink   cmd,
	fwa_stream_if.source rsp
);
	import fwa_pkg::*;

	// Widths derived from the queue depth.
	localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int SUM_RAW = $clog2(CAPACITY * ((1 << HEIGHT_W) - 1) + 1);
	localparam int SUM_W  = (SUM_RAW > HEIGHT_W) ? SUM_RAW : HEIGHT_W + 1;
	localparam int NUM_W  = SUM_W + 2;          // 2*sum + count
	localparam int DIV_W  = CNT_W + 1;          // 2*count
	localparam int WW     = (NUM_W > DIV_W + MEAN_W - 1) ? NUM_W : DIV_W + MEAN_W - 1;

	// Entry RAM: {tag, height} per slot, registered read.
	logic [ENTRY_W-1:0] mem [CAPACITY];
	logic [ENTRY_W-1:0] rd_q;

	// Control and queue state.
	fwa_state_t         state_q, state_nx;
	logic [SLOT_W-1:0]  oldest_q;
	logic [CNT_W-1:0]   count_q;
	logic [SUM_W-1:0]   sum_q;

	// Latched command.
	fwa_cmd_t           cmd_q;

	// Divider.
	logic [WW-1:0]      rem_q;
	logic [WW-1:0]      ds_q;
	logic [MEAN_W-1:0]  quot_q;
	logic [STEP_W-1:0]  step_q;

	// Pending result fields, set in the update cycle.
	logic               pend_kind_q;
	logic [TAG_W-1:0]   pend_tag_q;
	logic               pend_err_q;
	logic [HELD_W-1:0]  pend_held_q;

	// Output register.
	logic               rsp_valid_q;
	fwa_rsp_t           rsp_q;

	// Handshake / strobe signals.
	logic               accept;
	logic               out_load;
	logic               mem_we;

	// Update-cycle datapath.
	logic               is_insert;
	logic               full;
	logic               empty;
	logic [HEIGHT_W-1:0] old_height;
	logic [SLOT_W-1:0]  oldest_next;
	logic [SLOT_W:0]    tail_sum;
	logic [SLOT_W-1:0]  tail;
	logic [SUM_W-1:0]   sum_ins;
	logic [SUM_W-1:0]   sum_rem;
	logic [CNT_W-1:0]   count_ins;
	logic [CNT_W-1:0]   count_rem;
	logic [NUM_W-1:0]   numer;
	logic [DIV_W-1:0]   denom;
	logic [CNT_W+HELD_W-1:0] held_ext;

	// Divider step.
	logic               div_ge;
	logic [WW-1:0]      rem_nx;

	assign is_insert  = (cmd_q.mode == MODE_INSERT);
	assign full       = (count_q == CNT_W'(CAPACITY));
	assign empty      = (count_q == '0);
	assign old_height = rd_q[HEIGHT_W-1:0];
	assign oldest_next = (oldest_q == SLOT_W'(CAPACITY - 1)) ? '0 : oldest_q + 1'b1;

	// Tail slot: the freed oldest slot when full, else oldest + count wrapped.
	assign tail_sum = (SLOT_W+1)'(oldest_q) + (SLOT_W+1)'(count_q);
	always_comb begin
		if (full) begin
			tail = oldest_q;
		end else if (tail_sum >= (SLOT_W+1)'(CAPACITY)) begin
			tail = SLOT_W'(tail_sum - (SLOT_W+1)'(CAPACITY));
		end else begin
			tail = SLOT_W'(tail_sum);
		end
	end

	// Running sum: on insert drop the oldest height when full, then add the new one; on remove drop the oldest.
	assign sum_ins   = sum_q - (full ? SUM_W'(old_height) : '0) + SUM_W'(cmd_q.entry_height);
	assign sum_rem   = sum_q - SUM_W'(old_height);
	assign count_ins = full ? count_q : count_q + 1'b1;
	assign count_rem = count_q - 1'b1;

	// Mean = floor((2*sum + count) / (2*count)).
	assign numer = NUM_W'({sum_ins, 1'b0}) + NUM_W'(count_ins);
	assign denom = {count_ins, 1'b0};

	always_comb begin
		if (is_insert) begin
			held_ext = (CNT_W+HELD_W)'(count_ins);
		end else if (empty) begin
			held_ext = '0;
		end else begin
			held_ext = (CNT_W+HELD_W)'(count_rem);
		end
	end

	assign div_ge = (rem_q >= ds_q);
	assign rem_nx = div_ge ? rem_q - ds_q : rem_q;

	// Next-state logic.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.valid) begin
					state_nx = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_nx = is_insert ? ST_DIV : ST_FINISH;
			end
			ST_DIV: begin
				if (step_q == '0) begin
					state_nx = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_load) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// Output / strobe logic.
	always_comb begin
		cmd.ready = (state_q == ST_IDLE);
		accept    = cmd.valid && (state_q == ST_IDLE);
		mem_we    = (state_q == ST_EXEC) && is_insert;
		out_load  = (state_q == ST_FINISH) && (!rsp_valid_q || rsp.ready);
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	// Entry RAM: write the new entry in the update cycle, read the oldest on accept.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[tail] <= {cmd_q.entry_tag, cmd_q.entry_height};
		end
		if (accept) begin
			rd_q <= mem[oldest_q];
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			oldest_q    <= '0;
			count_q     <= '0;
			sum_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_EXEC) begin
				if (is_insert) begin
					oldest_q <= full ? oldest_next : oldest_q;
					count_q  <= count_ins;
					sum_q    <= sum_ins;
				end else if (!empty) begin
					oldest_q <= oldest_next;
					count_q  <= count_rem;
					sum_q    <= sum_rem;
				end
			end
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: command latch, divider, pending and output result.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd.payload;
		end
		case (state_q)
			ST_EXEC: begin
				pend_kind_q <= cmd_q.mode;
				pend_err_q  <= !is_insert && empty;
				pend_tag_q  <= (!is_insert && !empty) ? rd_q[ENTRY_W-1:HEIGHT_W] : '0;
				pend_held_q <= held_ext[HELD_W-1:0];
				quot_q      <= '0;
				rem_q       <= WW'(numer);
				ds_q        <= WW'(denom) << (MEAN_W - 1);
				step_q      <= STEP_W'(MEAN_W - 1);
			end
			ST_DIV: begin
				rem_q  <= rem_nx;
				ds_q   <= ds_q >> 1;
				quot_q <= {quot_q[MEAN_W-2:0], div_ge};
				step_q <= step_q - 1'b1;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			rsp_q.kind        <= pend_kind_q;
			rsp_q.mean_height <= quot_q;
			rsp_q.removed_tag <= pend_tag_q;
			rsp_q.empty_error <= pend_err_q;
			rsp_q.held_count  <= pend_held_q;
		end
	end

endmodule

### dv/fwa_mean_checker.sv
`timescale 1ns / 100ps
// Checker for the FIFO window average block: predicts each result and compares it field by field.
module fwa_mean_checker #(
	parameter int CAPACITY = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  logic              cmd_ready,
	input  fwa_pkg::fwa_cmd_t cmd_payload,
	input  logic              rsp_valid,
	input  logic              rsp_ready,
	input  fwa_pkg::fwa_rsp_t rsp_payload,
	output int                fail_count,
	output int                pending_results
);
	import fwa_pkg::*;

	logic [TAG_W-1:0]    held_tag    [CAPACITY];
	logic [HEIGHT_W-1:0] held_height [CAPACITY];
	int unsigned         head_slot;
	int unsigned         held_entries;
	int unsigned         height_total;
	fwa_rsp_t            expected_q [$];

	initial fail_count = 0;

	task automatic report_error(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		fail_count++;
	endtask

	task automatic compare_field(input string field, input int unsigned got,
			input int unsigned want);
		if (got != want)
			report_error($sformatf("%s is %0d, expected %0d", field, got, want));
	endtask

	function automatic void pop_oldest();
		height_total -= held_height[head_slot];
		head_slot = (head_slot + 1) % CAPACITY;
		held_entries--;
	endfunction

	// One queue operation on the shadow copy; returns the result it should produce.
	function automatic fwa_rsp_t window_step(input fwa_cmd_t item);
		fwa_rsp_t    res;
		int unsigned tail;
		res      = '0;
		res.kind = item.mode;
		if (item.mode == MODE_INSERT) begin
			// full queue: oldest entry goes silently
			if (held_entries >= CAPACITY)
				pop_oldest();
			tail = (head_slot + held_entries) % CAPACITY;
			held_tag[tail]    = item.entry_tag;
			held_height[tail] = item.entry_height;
			held_entries++;
			height_total += item.entry_height;
			// mean rounded half up
			res.mean_height = MEAN_W'((2 * height_total + held_entries) / (2 * held_entries));
		end else if (held_entries == 0) begin
			res.empty_error = 1'b1;
		end else begin
			res.removed_tag = held_tag[head_slot];
			pop_oldest();
		end
		res.held_count = HELD_W'(held_entries);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		fwa_rsp_t want;
		if (!arst_n) begin
			head_slot    = 0;
			held_entries = 0;
			height_total = 0;
			expected_q.delete();
			pending_results <= 0;
		end else begin
			// a result can never belong to an item taken at the same edge
			if (rsp_valid && rsp_ready) begin
				if (expected_q.size() == 0) begin
					report_error("result with nothing outstanding");
				end else begin
					want = expected_q.pop_front();
					compare_field("kind", rsp_payload.kind, want.kind);
					compare_field("mean_height", rsp_payload.mean_height, want.mean_height);
					compare_field("removed_tag", rsp_payload.removed_tag, want.removed_tag);
					compare_field("empty_error", rsp_payload.empty_error, want.empty_error);
					compare_field("held_count", rsp_payload.held_count, want.held_count);
				end
			end
			if (cmd_valid && cmd_ready)
				expected_q.push_back(window_step(cmd_payload));
			pending_results <= expected_q.size();
		end
	end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// Testbench top for the FIFO window average block: clock, reset, stimulus, flow control, verdict.
module tb;
	import fwa_pkg::*;

	localparam int CAPACITY     = 5;
	localparam int RANDOM_ITEMS = 900;
	localparam int HOLD_LEN     = 400;   // long receiver stall, fills the block and blocks cmd
	localparam int SETTLE_LEN   = 30;    // well past the insert latency

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   hold_cycles;
	int   fail_count;
	int   pending_results;
	int   remove_pct;

	fwa_stream_if #(.payload_t(fwa_cmd_t)) cmd_if ();
	fwa_stream_if #(.payload_t(fwa_rsp_t)) rsp_if ();

	bounded_fifo_window_average_top #(.CAPACITY(CAPACITY)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.rsp    (rsp_if)
	);

	fwa_mean_checker #(.CAPACITY(CAPACITY)) watch (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (cmd_if.valid),
		.cmd_ready       (cmd_if.ready),
		.cmd_payload     (cmd_if.payload),
		.rsp_valid       (rsp_if.valid),
		.rsp_ready       (rsp_if.ready),
		.rsp_payload     (rsp_if.payload),
		.fail_count      (fail_count),
		.pending_results (pending_results)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("tb: FAIL");
		$finish;
	end

	// Receiver side: random backpressure, or a counted hold-off when one is requested.
	initial begin
		rsp_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Offer one item, with random idle cycles first; returns at the accepting edge.
	// valid stays high afterwards so back-to-back items need no extra step.
	task automatic send_item(input logic mode, input logic [TAG_W-1:0] tag,
			input logic [HEIGHT_W-1:0] height);
		fwa_cmd_t item;
		item.mode         = mode;
		item.entry_tag    = tag;
		item.entry_height = height;
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_if.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_if.valid   <= 1'b1;
		cmd_if.payload <= item;
		@(posedge clk);
		while (!cmd_if.ready)
			@(posedge clk);
	endtask

	// Drop valid and sit until the block has returned everything.
	task automatic wait_drained();
		cmd_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [HEIGHT_W-1:0] height;
		cmd_if.valid   = 1'b0;
		cmd_if.payload = '0;
		send_idle_pct  = 18;
		recv_idle_pct  = 67;
		hold_cycles    = 0;
		remove_pct     = 25;
		arst_n         = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---
		// remove on an empty queue: error flag, nothing changes
		send_item(MODE_REMOVE, '1, '1);
		// field extremes
		send_item(MODE_INSERT, '0, '0);
		send_item(MODE_INSERT, '1, '1);
		send_item(MODE_REMOVE, '0, '0);
		send_item(MODE_REMOVE, '0, '0);
		send_item(MODE_REMOVE, '0, '0);
		// heights 0 and 1: mean of exactly one half must round up
		send_item(MODE_INSERT, 12'd1, 10'd0);
		send_item(MODE_INSERT, 12'd2, 10'd1);
		// fill past capacity: oldest entries dropped without a report
		for (int i = 0; i < 6; i++)
			send_item(MODE_INSERT, 12'(100 + i), 10'd1023);
		// drain completely, then one more remove on empty
		for (int i = 0; i < CAPACITY + 1; i++)
			send_item(MODE_REMOVE, 12'($urandom_range(4095)), 10'($urandom_range(1023)));

		// --- random part ---
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// idling phases: sender light / receiver heavy, then swapped, then none
			if (i == 300) begin
				send_idle_pct = 67;
				recv_idle_pct = 18;
			end else if (i == 600) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			// long receiver stall while items keep coming
			if (i == 100)
				hold_cycles = HOLD_LEN;
			// sender pause until every result is back
			if (i == 450)
				wait_drained();
			// alternate insert-heavy and remove-heavy stretches so the queue
			// swings between full (overflow drops) and empty (remove errors)
			if (i % 40 == 0)
				remove_pct = (remove_pct == 25) ? 65 : 25;
			case ($urandom_range(9))
				0:       height = '0;
				1:       height = '1;
				default: height = 10'($urandom_range(1023));
			endcase
			send_item(($urandom_range(99) < remove_pct) ? MODE_REMOVE : MODE_INSERT,
				12'($urandom_range(4095)), height);
		end

		wait_drained();
		// stray results after the last expected one are caught here
		repeat (SETTLE_LEN) @(posedge clk);
		if (fail_count == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

### sim.f
sv/fwa_pkg.sv
sv/fwa_stream_if.sv
sv/bounded_fifo_window_average_top.sv
dv/fwa_mean_checker.sv
dv/tb.sv
